// File: sv/fbaq_pkg.sv
package fbaq_pkg;

    localparam int MaxBlockDef = 64;

    localparam logic [30:0] PosInf    = 31'h7F800000;
    localparam logic [30:0] MinAmax   = 31'h38D1B717;
    localparam logic [7:0]  ScaleInf  = 8'd255;
    localparam logic [6:0]  MagMax    = 7'h7E;

    typedef struct packed {
        logic [7:0] scode;
        logic       ovf;
        logic       inf;
        logic [6:0] count;
    } t_blk;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_EMIT
    } t_state;

    function automatic logic rnd_up(input logic [23:0] rem, input logic lsb);
        begin
            rnd_up = (rem > 24'h800000) || ((rem == 24'h800000) && lsb);
        end
    endfunction

    // Scale from block maximum: ceil(log2(max(amax,1e-4)/448)) as E8M0.
    function automatic logic [7:0] calc_scode(input logic [30:0] amax, input logic inf);
        logic [30:0] m;
        logic [23:0] sig;
        logic [47:0] prod;
        logic [8:0]  e;
        logic [8:0]  sc;
        logic        up;
        begin
            m = (amax < MinAmax) ? MinAmax : amax;
            // v = m * (1/448) in float: 1/448 = 1.142857.. * 2^-9, mantissa 0x124925
            sig = {1'b1, m[22:0]};
            prod = sig * 24'h924925;
            e = {1'b0, m[30:23]} - 9'd9;
            if (prod[47]) begin
                e = e + 9'd1;
                up = (prod[46:24] != 23'd0) || rnd_up(prod[23:0], prod[24]);
            end else begin
                up = (prod[45:23] != 23'd0) || rnd_up({prod[22:0], 1'b0}, prod[23]);
            end
            sc = e + {8'd0, up};
            if (inf || sc > 9'd255) calc_scode = ScaleInf;
            else calc_scode = sc[7:0];
        end
    endfunction

    // Encode element x scaled by 2^(127-scode) (scode < 255) as E4M3.
    function automatic logic [7:0] encode(input logic [31:0] x, input logic [7:0] scode);
        logic        s;
        logic [7:0]  ex;
        logic [22:0] man;
        logic signed [10:0] e;
        logic [23:0] sig;
        logic [26:0] sh;
        logic [4:0]  amt;
        logic [3:0]  keep;
        logic [4:0]  ee;
        logic [6:0]  mag;
        logic [23:0] rem;
        begin
            s = x[31];
            ex = x[30:23];
            man = x[22:0];
            mag = 7'd0;
            if (ex == 8'hFF) begin
                mag = MagMax;
            end else if (ex != 8'd0) begin
                // unbiased scaled exponent
                e = $signed({3'b0, ex}) - $signed({3'b0, scode});
                sig = {1'b1, man};
                if (e > 11'sd8) begin
                    mag = MagMax;
                end else if (e >= -11'sd6) begin
                    keep = {1'b0, sig[22:20]};
                    rem = {4'd0, sig[19:0]};
                    if (rem > 24'h80000 || (rem == 24'h80000 && keep[0])) keep = keep + 4'd1;
                    ee = 5'(e + 11'sd7);
                    if (keep == 4'd8) begin
                        keep = 4'd0;
                        ee = ee + 5'd1;
                    end
                    if (ee > 5'd15 || (ee == 5'd15 && keep == 4'd7)) mag = MagMax;
                    else mag = {ee[3:0], keep[2:0]};
                end else if (e >= -11'sd10) begin
                    // subnormal: value*512 = sig * 2^(e+9-23)
                    amt = 5'(-11'sd6 - e + 11'sd20);
                    sh = {3'b0, sig} >> amt;
                    rem = sig & ((24'd1 << amt) - 24'd1);
                    keep = sh[3:0];
                    if (rem > (24'd1 << (amt - 5'd1)) ||
                        (rem == (24'd1 << (amt - 5'd1)) && keep[0]))
                        keep = keep + 4'd1;
                    mag = {3'b0, keep};
                end
            end
            encode = {s, mag};
        end
    endfunction

endpackage

// File: sv/fbaq_front.sv
module fbaq_front #(
    parameter int MaxBlock = fbaq_pkg::MaxBlockDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [31:0]          i_element_bits,
    input  logic                 i_last,
    output logic                 o_push,
    output fbaq_pkg::t_blk       o_blk,
    output logic                 o_wr,
    output logic [$clog2(MaxBlock+1)-1:0] o_waddr
);
    localparam int CW = $clog2(MaxBlock + 1);

    logic [CW-1:0] r_cnt;
    logic [30:0]   r_max;
    logic          r_ovf;
    logic          r_inf;
    logic [CW-1:0] n_cnt;
    logic [30:0]   n_max;
    logic          n_ovf;
    logic          n_inf;
    logic [30:0]   a;
    logic          room;

    assign a = i_element_bits[30:0];
    assign room = (r_cnt < CW'(MaxBlock));
    assign o_wr = i_take && room;
    assign o_waddr = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        n_max = r_max;
        n_ovf = r_ovf;
        n_inf = r_inf;
        if (i_take) begin
            if (room) begin
                n_cnt = r_cnt + CW'(1);
                if (a == fbaq_pkg::PosInf) n_inf = 1'b1;
                if (a <= fbaq_pkg::PosInf && a > r_max) n_max = a;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_push = i_take && i_last;
    always_comb begin
        o_blk.scode = fbaq_pkg::calc_scode(n_max, n_inf);
        o_blk.ovf = n_ovf;
        o_blk.inf = n_inf;
        o_blk.count = 7'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt <= '0;
            r_max <= '0;
            r_ovf <= 1'b0;
            r_inf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_max <= n_max;
            r_ovf <= n_ovf;
            r_inf <= n_inf;
        end
    end
endmodule

// File: sv/fbaq_back.sv
module fbaq_back #(
    parameter int MaxBlock = fbaq_pkg::MaxBlockDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fbaq_pkg::t_blk i_blk,
    output logic           o_pop,
    output logic [$clog2(MaxBlock+1)-1:0] o_raddr,
    input  logic [31:0]    i_rdata,
    output logic           o_valid,
    output logic [7:0]     o_fp8_code,
    output logic [7:0]     o_scale_code,
    output logic [5:0]     o_position,
    output logic           o_end_of_block,
    output logic           o_overflowed,
    output logic           o_nonfinite,
    output logic           o_busy
);
    localparam int CW = $clog2(MaxBlock + 1);

    fbaq_pkg::t_state r_state, n_state;
    fbaq_pkg::t_blk   r_blk;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rd;
    logic [CW-1:0]    r_ridx;
    logic             r_last;

    assign o_raddr = r_idx;
    assign o_busy = (r_state != fbaq_pkg::ST_FILL) || r_rd;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_pop = 1'b0;
        case (r_state)
            fbaq_pkg::ST_FILL: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                    n_state = fbaq_pkg::ST_EMIT;
                end
            end
            fbaq_pkg::ST_EMIT: begin
                n_idx = r_idx + CW'(1);
                if (7'(r_idx) + 7'd1 >= r_blk.count) n_state = fbaq_pkg::ST_FILL;
            end
            default: n_state = fbaq_pkg::ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbaq_pkg::ST_FILL;
            r_idx <= '0;
            r_rd <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_rd <= (r_state == fbaq_pkg::ST_EMIT);
        end
        if (o_pop) r_blk <= i_blk;
        r_ridx <= r_idx;
        r_last <= (7'(r_idx) + 7'd1 >= r_blk.count);
    end

    assign o_valid = r_rd;
    assign o_fp8_code = r_blk.inf ? 8'd0 : fbaq_pkg::encode(i_rdata, r_blk.scode);
    assign o_scale_code = r_blk.scode;
    assign o_position = 6'(r_ridx);
    assign o_end_of_block = r_last;
    assign o_overflowed = r_blk.ovf;
    assign o_nonfinite = r_blk.inf;
endmodule

// File: sv/fp8_block_activation_quantizer_core.sv
// Path: a block's results follow its last request through r_qblk, ST_EMIT and r_rdata.
// Throughput: one request per cycle while filling, then one result per cycle
// for each stored element; busy stays high while a block drains from the store.
// Reset: synchronous active-low i_rst_n clears counts, flags and state.
// The receiver cannot stall; each result shows for one cycle with o_valid.
module fp8_block_activation_quantizer_core #(
    parameter int MaxBlock = fbaq_pkg::MaxBlockDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_element_bits,
    input  logic        i_last,
    output logic        o_valid,
    output logic [7:0]  o_fp8_code,
    output logic [7:0]  o_scale_code,
    output logic [5:0]  o_position,
    output logic        o_end_of_block,
    output logic        o_overflowed,
    output logic        o_nonfinite
);
    localparam int CW = $clog2(MaxBlock + 1);
    localparam int AW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;

    logic           take, push, pop, wr, bbusy;
    logic           r_qv;
    fbaq_pkg::t_blk blk, r_qblk;
    logic [CW-1:0]  waddr, raddr;
    logic [31:0]    r_mem [MaxBlock];
    logic [31:0]    r_rdata;

    assign busy = r_qv || bbusy;
    assign take = start && !busy;

    fbaq_front #(.MaxBlock(MaxBlock)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_element_bits, .i_last,
        .o_push(push), .o_blk(blk), .o_wr(wr), .o_waddr(waddr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qv <= 1'b0;
        else if (push) r_qv <= 1'b1;
        else if (pop) r_qv <= 1'b0;
        if (push) r_qblk <= blk;
        if (wr) r_mem[waddr[AW-1:0]] <= i_element_bits;
        r_rdata <= r_mem[raddr[AW-1:0]];
    end

    fbaq_back #(.MaxBlock(MaxBlock)) u_back (
        .i_clk, .i_rst_n, .i_valid(r_qv), .i_blk(r_qblk), .o_pop(pop),
        .o_raddr(raddr), .i_rdata(r_rdata), .o_valid, .o_fp8_code, .o_scale_code,
        .o_position, .o_end_of_block, .o_overflowed, .o_nonfinite, .o_busy(bbusy)
    );
endmodule
